### rtl/pva_pkg.sv
`default_nettype none
package pva_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 24;
    localparam int COORD_W      = 24;
    localparam int AREA_W       = 57;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int ACC_W        = AREA_W + 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int COORD_SH     = COORD_W - COORD_BITS;

    localparam logic signed [ACC_W-1:0] SUM_LIMIT =
        ACC_W'(MAX_VERTICES) <<< (2 * COORD_BITS - 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [AREA_W-1:0]  t_area;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    // one cross product to accumulate; last closes the polygon
    typedef struct packed {
        t_vec a;
        t_vec b;
        logic last;
        logic sat;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // only the low COORD_BITS bits carry the coordinate
    function automatic t_coord sext_coord(input t_coord raw);
        t_coord s;
        s = raw <<< COORD_SH;
        return s >>> COORD_SH;
    endfunction

    function automatic t_area sat_add(input t_area sum, input t_cross term);
        logic signed [ACC_W-1:0] s;
        s = ACC_W'(sum) + ACC_W'(term);
        if (s > SUM_LIMIT) begin
            s = SUM_LIMIT;
        end else if (s < -SUM_LIMIT) begin
            s = -SUM_LIMIT;
        end
        return AREA_W'(s);
    endfunction

endpackage
`default_nettype wire

### rtl/pva_queue.sv
`default_nettype none
module pva_queue
    import pva_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_job    i_job,
    input  wire logic    i_pop,
    output t_job         o_job,
    output t_q_stat      o_stat
);

    t_job                r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wr;
    logic [Q_AW-1:0]     r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/pva_front.sv
`default_nettype none
module pva_front
    import pva_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_coord  i_x,
    input  wire t_coord  i_y,
    input  wire t_coord  i_z,
    input  wire logic    i_last_vertex,
    output logic         o_stall,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_job         o_job
);

    t_vec             r_first;
    t_vec             r_prev;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_close_pend;
    t_job             r_close_job;

    t_vec             cur;
    logic             accept;
    logic             at_max;

    assign cur.x  = sext_coord(i_x);
    assign cur.y  = sext_coord(i_y);
    assign cur.z  = sext_coord(i_z);
    assign at_max = (r_count == CNT_W'(MAX_VERTICES));

    assign o_stall = r_close_pend | i_q_stat.full;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        o_push = 1'b0;
        o_job  = r_close_job;
        if (r_close_pend) begin
            o_push = ~i_q_stat.full;
        end else if (accept) begin
            // a lone vertex crossed with itself gives the zero closing term
            o_push      = (r_count != '0) | i_last_vertex;
            o_job.a     = (r_count == '0) ? cur : r_prev;
            o_job.b     = cur;
            o_job.last  = (r_count == '0);
            o_job.sat   = r_ovf | at_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= '0;
            r_prev       <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_close_pend <= 1'b0;
            r_close_job  <= '0;
        end else begin
            if (r_close_pend && !i_q_stat.full) begin
                r_close_pend <= 1'b0;
            end
            if (accept) begin
                if (r_count == '0) begin
                    r_first <= cur;
                end
                r_prev <= cur;
                if (i_last_vertex) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_first <= '0;
                    r_prev  <= '0;
                    if (r_count != '0) begin
                        r_close_pend     <= 1'b1;
                        r_close_job.a    <= cur;
                        r_close_job.b    <= r_first;
                        r_close_job.last <= 1'b1;
                        r_close_job.sat  <= r_ovf | at_max;
                    end
                end else begin
                    r_count <= at_max ? r_count : r_count + 1'b1;
                    r_ovf   <= r_ovf | at_max;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/pva_back.sv
`default_nettype none
module pva_back
    import pva_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_job    i_job,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_area        o_area_x,
    output t_area        o_area_y,
    output t_area        o_area_z,
    output logic         o_saturated
);

    logic   r_v1, r_last1, r_sat1;
    t_prod  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic   r_v2, r_last2, r_sat2;
    t_cross r_cx, r_cy, r_cz;
    t_area  r_sum_x, r_sum_y, r_sum_z;
    logic   r_out_valid, r_out_sat;
    t_area  r_out_x, r_out_y, r_out_z;

    logic   en;
    t_area  n_sum_x, n_sum_y, n_sum_z;

    // the whole pipe holds only while a finished result waits
    assign en    = ~(r_out_valid & i_stall);
    assign o_pop = en & ~i_q_stat.empty;

    assign n_sum_x = sat_add(r_sum_x, r_cx);
    assign n_sum_y = sat_add(r_sum_y, r_cy);
    assign n_sum_z = sat_add(r_sum_z, r_cz);

    assign o_valid     = r_out_valid;
    assign o_area_x    = r_out_x;
    assign o_area_y    = r_out_y;
    assign o_area_z    = r_out_z;
    assign o_saturated = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last1 <= i_job.last;
            r_sat1  <= i_job.sat;
            r_p0    <= PROD_W'(i_job.a.y) * PROD_W'(i_job.b.z);
            r_p1    <= PROD_W'(i_job.a.z) * PROD_W'(i_job.b.y);
            r_p2    <= PROD_W'(i_job.a.z) * PROD_W'(i_job.b.x);
            r_p3    <= PROD_W'(i_job.a.x) * PROD_W'(i_job.b.z);
            r_p4    <= PROD_W'(i_job.a.x) * PROD_W'(i_job.b.y);
            r_p5    <= PROD_W'(i_job.a.y) * PROD_W'(i_job.b.x);
            r_last2 <= r_last1;
            r_sat2  <= r_sat1;
            r_cx    <= CROSS_W'(r_p0) - CROSS_W'(r_p1);
            r_cy    <= CROSS_W'(r_p2) - CROSS_W'(r_p3);
            r_cz    <= CROSS_W'(r_p4) - CROSS_W'(r_p5);
            if (r_v2 && r_last2) begin
                r_out_x   <= n_sum_x;
                r_out_y   <= n_sum_y;
                r_out_z   <= n_sum_z;
                r_out_sat <= r_sat2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
        end else if (en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 & r_last2;
            if (r_v2) begin
                if (r_last2) begin
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_sum_z <= '0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_sum_z <= n_sum_z;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/polygon_vector_area_unit.sv
// the result is valid once the closing cross product, registered first in the front for two or more vertices,
// has passed the job queue and the back; a lone vertex needs no separate closing cross product
// throughput: one vertex per cycle while o_stall is low; a polygon of two or more vertices
// also raises o_stall while the front pushes the closing cross product into the job queue
// the back runs products, cross terms and saturating accumulate as three register stages
// reset (synchronous, active low) empties the queue and clears sums, counters and valids
`default_nettype none
module polygon_vector_area_unit
    import pva_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_coord  i_x,
    input  wire t_coord  i_y,
    input  wire t_coord  i_z,
    input  wire logic    i_last_vertex,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_area        o_area_x,
    output t_area        o_area_y,
    output t_area        o_area_z,
    output logic         o_saturated
);

    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    t_job    push_job;
    t_job    pop_job;

    pva_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_z           (i_z),
        .i_last_vertex (i_last_vertex),
        .o_stall       (o_stall),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    pva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    pva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (pop_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_area_x    (o_area_x),
        .o_area_y    (o_area_y),
        .o_area_z    (o_area_z),
        .o_saturated (o_saturated)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("job popped from an empty queue");

    a_no_pop_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !q_pop)
        else $error("back pipe advanced while a result is held");

endmodule
`default_nettype wire
